FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the bitmap block allocator
// Request codes, bitmap word geometry and the word scan result type.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Default capacity of the bitmap in blocks.
    localparam int MaxBlocksDefault = 4096;

    // The bitmap is stored as words of 64 block bits, lowest block in bit 0.
    localparam int WordBits  = 64;
    localparam int WordPosW  = 6;

    // Width used for block positions inside the scan (covers 65536 + 64).
    localparam int PosW = 18;

    // Field widths of the request and result transfers.
    localparam int ModeW  = 2;
    localparam int IndexW = 12;
    localparam int CfgW   = 13;

    // Reset value of the blocks_in_use register.
    localparam logic [CfgW-1:0] BlocksInUseReset = 13'd4096;

    // Request codes.
    typedef enum logic [ModeW-1:0] {
        MODE_USE  = 2'd0,
        MODE_FREE = 2'd1,
        MODE_FIND = 2'd2,
        MODE_BAD  = 2'd3
    } t_mode;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Result of scanning one bitmap word.
    typedef struct packed {
        logic                hit;
        logic                last;
        logic [WordPosW-1:0] pos;
    } t_scan_res;

endpackage

FILE: src/bba_word_scan.sv
// ----------------------------------------------------------------------------
// bba_word_scan: free bit search over one bitmap word
// Masks off blocks at or above the valid limit and returns the lowest free
// bit of the word, plus whether this word is the last one below the limit.
// ----------------------------------------------------------------------------
module bba_word_scan (
    input  logic [bba_pkg::PosW-1:0]     i_base,
    input  logic [bba_pkg::CfgW-1:0]     i_limit,
    input  logic [bba_pkg::WordBits-1:0] i_word,
    output bba_pkg::t_scan_res           o_res
);
    import bba_pkg::*;

    logic [PosW-1:0]     limit_ext;
    logic [PosW-1:0]     remain;
    logic [WordBits-1:0] free_bits;

    // Number of valid blocks from this word on; the caller only scans words
    // that start below the limit.
    assign limit_ext = PosW'(i_limit);
    assign remain    = limit_ext - i_base;

    // A bit is free when it is clear and its block lies below the limit.
    always_comb begin
        for (int j = 0; j < WordBits; j++) begin
            free_bits[j] = ~i_word[j] & (PosW'(j) < remain);
        end
    end

    // Lowest free bit wins.
    always_comb begin
        o_res.pos = '0;
        for (int j = WordBits - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                o_res.pos = WordPosW'(j);
            end
        end
        o_res.hit  = |free_bits;
        o_res.last = (i_base + PosW'(WordBits)) >= limit_ext;
    end

endmodule

FILE: src/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: free-space bitmap with find-first-free
// Keeps one used/free bit per block in a single-port-write memory of
// 64-bit words and serves mark used, mark free and find requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_axis channel, one transfer each; every request
// produces exactly one result transfer on the m_axis channel. The register
// blocks_in_use (APB, address 0) limits the valid blocks; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// Flow: a mark reads its bitmap word on acceptance, writes it back in the mark
// state and then hands its result on from the response state. A find reads one
// 64-bit bitmap word per cycle and stops at the first word with a free block
// below the limit, or at the last word below it, then hands its result on from
// the response state. Either way the next request is taken back in idle.
// One request is in work at a time; s_axis_tready is high only while the
// block waits for a request. The next request is taken while the previous
// result still waits in the output register.
// If the receiver stalls, the finished result waits until the output
// register is free, and the block takes no new request meanwhile.
// Reset: a clearing pass writes zeros to every bitmap word, one word per
// cycle; no request is accepted during it.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MaxBlocksDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [1:0] mode, [13:2] block_index, [15:14] zero
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] status, [12:1] found_index, [15:13] zero
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bba_pkg::*;

    localparam int Depth = (MAX_BLOCKS + WordBits - 1) / WordBits;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam logic [CfgW-1:0] MaxClip =
        (MAX_BLOCKS > 8191) ? {CfgW{1'b1}} : CfgW'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MARK,
        S_FIND,
        S_RESP
    } t_state;

    // Bitmap storage
    logic [WordBits-1:0] mem [Depth];
    logic [WordBits-1:0] r_rdata;

    t_state              r_state;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_eval_addr;
    logic [AW-1:0]       r_mark_addr;
    logic [WordPosW-1:0] r_mark_bit;
    logic                r_mark_set;
    logic                r_res_status;
    logic [IndexW-1:0]   r_res_found;
    logic                r_out_valid;
    logic                r_out_status;
    logic [IndexW-1:0]   r_out_found;
    logic [CfgW-1:0]     r_blocks_in_use;

    logic [ModeW-1:0]    in_mode;
    logic [IndexW-1:0]   in_index;
    logic                in_accept;
    logic [CfgW-1:0]     limit;
    logic                in_range;
    logic                out_free;
    logic [PosW-1:0]     scan_base;
    t_scan_res           scan;

    logic                w_en;
    logic [AW-1:0]       w_addr;
    logic [WordBits-1:0] w_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [WordBits-1:0] bit_sel;

    // Field unpacking and handshake
    assign in_mode       = s_axis_tdata[1:0];
    assign in_index      = s_axis_tdata[13:2];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_out_valid | m_axis_tready;

    // Valid limit saturates at the bitmap capacity.
    assign limit    = (r_blocks_in_use > MaxClip) ? MaxClip : r_blocks_in_use;
    assign in_range = {1'b0, in_index} < limit;

    // Scan of the word read in the previous cycle.
    assign scan_base = PosW'(r_eval_addr) << WordPosW;

    bba_word_scan u_scan (
        .i_base  (scan_base),
        .i_limit (limit),
        .i_word  (r_rdata),
        .o_res   (scan)
    );

    assign bit_sel = WordBits'(1) << r_mark_bit;

    // Memory port control
    always_comb begin
        w_en    = 1'b0;
        w_addr  = r_clr_addr;
        w_data  = '0;
        rd_en   = 1'b0;
        rd_addr = r_eval_addr + AW'(1);
        case (r_state)
            S_CLEAR: begin
                w_en = 1'b1;
            end
            S_IDLE: begin
                rd_en   = in_accept;
                rd_addr = (in_mode == MODE_FIND) ? '0 : AW'(in_index >> WordPosW);
            end
            S_MARK: begin
                w_en   = 1'b1;
                w_addr = r_mark_addr;
                w_data = r_mark_set ? (r_rdata | bit_sel) : (r_rdata & ~bit_sel);
            end
            S_FIND: begin
                rd_en = ~scan.hit & ~scan.last;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Bitmap memory with registered read data
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register is loaded from the response state, or
            // emptied once the receiver takes the transfer.
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(Depth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_res_status <= STATUS_ERROR;
                        r_res_found  <= '0;
                        r_mark_addr  <= AW'(in_index >> WordPosW);
                        r_mark_bit   <= in_index[WordPosW-1:0];
                        r_mark_set   <= (in_mode == MODE_USE);
                        r_eval_addr  <= '0;
                        case (in_mode)
                            MODE_USE, MODE_FREE: begin
                                r_state <= in_range ? S_MARK : S_RESP;
                            end
                            MODE_FIND: begin
                                r_state <= (limit == '0) ? S_RESP : S_FIND;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_MARK: begin
                    r_res_status <= STATUS_OK;
                    r_res_found  <= '0;
                    r_state      <= S_RESP;
                end
                S_FIND: begin
                    if (scan.hit) begin
                        r_res_status <= STATUS_OK;
                        r_res_found  <= IndexW'(scan_base + PosW'(scan.pos));
                        r_state      <= S_RESP;
                    end else if (scan.last) begin
                        r_res_status <= STATUS_ERROR;
                        r_res_found  <= '0;
                        r_state      <= S_RESP;
                    end else begin
                        r_eval_addr <= r_eval_addr + AW'(1);
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_found  <= r_res_found;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_found, r_out_status};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= BlocksInUseReset;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_blocks_in_use <= pwdata[CfgW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - CfgW){1'b0}}, r_blocks_in_use} : '0;

endmodule

FILE: tb/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker: request/result scoreboard for the bitmap block allocator
// Watches the request, result and register channels, keeps its own copy of
// the block usage map and the block limit, predicts one result per request
// and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module bba_checker #(
    parameter int         MAX_BLOCKS = bba_pkg::MaxBlocksDefault,
    parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [15:0] i_req_data,    // [1:0] mode, [13:2] block_index, [15:14] zero
    // Result channel
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_data,    // [0] status, [12:1] found_index, [15:13] zero
    // Register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    // Counters for the testbench top
    output int          o_fail_count,
    output int          o_pending,
    output int          o_request_count,
    output int          o_result_count,
    output int          o_hit_count,
    output int          o_full_count
);
    import bba_pkg::*;

    typedef struct packed {
        logic              status;
        logic [IndexW-1:0] found;
    } t_alloc_res;

    // Shadow of the usage map (one bit per block, set means used).
    logic [MAX_BLOCKS-1:0] used_map;
    logic [CfgW-1:0]       limit_reg;
    t_alloc_res            awaited_results[$];

    // Applies one request to the shadow map and returns its result.
    function automatic t_alloc_res serve_request(input t_mode op,
                                                 input logic [IndexW-1:0] idx);
        t_alloc_res res;
        int         lim;
        lim = (int'(limit_reg) > MAX_BLOCKS) ? MAX_BLOCKS : int'(limit_reg);
        res.status = STATUS_ERROR;
        res.found  = '0;
        case (op)
            MODE_USE, MODE_FREE: begin
                if (int'(idx) < lim) begin
                    used_map[idx] = (op == MODE_USE);
                    res.status    = STATUS_OK;
                end
            end
            MODE_FIND: begin
                for (int i = 0; i < lim; i++) begin
                    if (!used_map[i]) begin
                        res.status = STATUS_OK;
                        res.found  = IndexW'(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_request_count = 0;
        o_result_count  = 0;
        o_hit_count     = 0;
        o_full_count    = 0;
    end

    // Results are retired before the request of the same edge is predicted,
    // since a result can never belong to a request taken at that edge.
    always @(posedge i_clk) begin : scoreboard
        t_alloc_res got;
        t_alloc_res want;
        t_mode      op;
        if (!i_rst_n) begin
            used_map  = '0;
            limit_reg = BlocksInUseReset;
            awaited_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got.status = i_res_data[0];
                got.found  = i_res_data[IndexW:1];
                o_result_count++;
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result transfer with none expected, status %0d index %0d",
                             $time, got.status, got.found);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t ns: status mismatch, expected %0d actual %0d",
                                 $time, want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.found !== want.found) begin
                        $display("%0t ns: found_index mismatch, expected %0d actual %0d",
                                 $time, want.found, got.found);
                        o_fail_count++;
                    end
                end
            end

            if (i_req_valid && i_req_ready) begin
                op   = t_mode'(i_req_data[ModeW-1:0]);
                want = serve_request(op, i_req_data[ModeW+IndexW-1:ModeW]);
                awaited_results.push_back(want);
                o_request_count++;
                if (op == MODE_FIND) begin
                    if (want.status == STATUS_OK)
                        o_hit_count++;
                    else
                        o_full_count++;
                end
            end

            // Register write completes in the access phase.
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LIMIT_ADDR)
                limit_reg = i_pwdata[CfgW-1:0];
        end
        o_pending = awaited_results.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the bitmap block allocator
// Drives mark used, mark free and find requests in random bursts, changes the
// block limit between phases over its whole range, stalls the result side
// on changing patterns and lets the checker compare every result.
// ----------------------------------------------------------------------------
module testbench;
    import bba_pkg::*;

    localparam int         ClkHalf        = 10;
    localparam int         CycleLimit     = 1_500_000;
    localparam int         RandomRequests = 1750;
    localparam logic [2:0] RegBlocksInUse = 3'd0;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [1:0] mode, [13:2] block_index, [15:14] zero
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;           // [0] status, [12:1] found_index, [15:13] zero
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    wire  [31:0] prdata;
    wire         pready;

    int fail_count;
    int pending;
    int request_count;
    int result_count;
    int hit_count;
    int full_count;

    int cycles      = 0;
    int stall_style = 0;
    int burst_left;
    int fill_cursor;
    int eff_limit;
    int limit_writes;

    always #ClkHalf i_clk = ~i_clk;

    bitmap_block_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bba_checker #(
        .LIMIT_ADDR (RegBlocksInUse)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .i_req_ready     (s_axis_tready),
        .i_req_data      (s_axis_tdata),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_data      (m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_request_count (request_count),
        .o_result_count  (result_count),
        .o_hit_count     (hit_count),
        .o_full_count    (full_count)
    );

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side backpressure; the stall pattern is drawn anew at random from four styles.
    always @(negedge i_clk) begin
        if (cycles % 256 == 0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((cycles % 7) < 3);
        endcase
    end

    // Drops tvalid and idles, n setting the length of the pause; called at a falling edge, n >= 1.
    task automatic go_quiet(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Offers one request and waits for its transfer; ends a burst with a gap.
    task automatic send_req(input t_mode op, input logic [IndexW-1:0] idx);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            case ($urandom_range(0, 19))
                0:             gap = $urandom_range(30, 90);
                1, 2, 3, 4, 5: gap = $urandom_range(4, 12);
                default:       gap = $urandom_range(1, 3);
            endcase
            go_quiet(gap);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Holds off the sender until every outstanding result has been taken.
    task automatic drain();
        go_quiet(1);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Writes the block limit once the allocator is idle.
    task automatic write_limit(input int value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= RegBlocksInUse;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eff_limit = (value > MaxBlocksDefault) ? MaxBlocksDefault : value;
        limit_writes++;
    endtask

    // Mostly sequential allocation with holes punched behind the fill
    // point, so finds have to scan past used words; the rest is noise.
    task automatic random_request();
        int                pick;
        t_mode             op;
        logic [IndexW-1:0] idx;
        pick = $urandom_range(0, 99);
        idx  = IndexW'($urandom);
        if (pick < 40) begin
            op  = MODE_USE;
            idx = IndexW'(fill_cursor);
            fill_cursor++;
            if (fill_cursor >= eff_limit || fill_cursor >= MaxBlocksDefault)
                fill_cursor = 0;
        end else if (pick < 60) begin
            op = MODE_FIND;
        end else if (pick < 75) begin
            op  = MODE_FREE;
            idx = IndexW'($urandom_range(0, fill_cursor));
        end else if (pick < 85) begin
            op = MODE_USE;
        end else if (pick < 95) begin
            op = MODE_FREE;
        end else begin
            op = MODE_BAD;
        end
        send_req(op, idx);
    endtask

    initial begin : stimulus
        int sent;
        int phase_left;
        int new_limit;
        burst_left   = 4;
        fill_cursor  = 0;
        eff_limit    = MaxBlocksDefault;
        limit_writes = 0;
        sent         = 0;
        phase_left   = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default limit: empty map, both ends of the index range, bad mode.
        send_req(MODE_FIND, 12'd0);
        send_req(MODE_USE, 12'd0);
        send_req(MODE_FIND, 12'hfff);
        send_req(MODE_USE, 12'hfff);
        send_req(MODE_FIND, 12'd0);
        send_req(MODE_FREE, 12'hfff);
        send_req(MODE_BAD, 12'hfff);
        send_req(MODE_FREE, 12'd0);
        send_req(MODE_USE, 12'd1);
        send_req(MODE_FIND, 12'd0);

        // Single valid block: out of range marks and a full map.
        write_limit(1);
        send_req(MODE_USE, 12'd0);
        send_req(MODE_USE, 12'd1);
        send_req(MODE_FIND, 12'd0);
        send_req(MODE_FREE, 12'd0);
        send_req(MODE_FREE, 12'hfff);
        send_req(MODE_FIND, 12'd0);

        // No valid blocks at all.
        write_limit(0);
        send_req(MODE_USE, 12'd0);
        send_req(MODE_FREE, 12'd0);
        send_req(MODE_FIND, 12'd0);

        // Limit above capacity saturates to the full map.
        write_limit(8191);
        send_req(MODE_USE, 12'hfff);
        send_req(MODE_FREE, 12'hfff);
        send_req(MODE_FIND, 12'd0);

        // Random phases, each under a fresh limit.
        while (sent < RandomRequests) begin
            if (phase_left <= 0) begin
                case ($urandom_range(0, 19))
                    0, 1, 2:           new_limit = MaxBlocksDefault;
                    3, 4:              new_limit = $urandom_range(4097, 8191);
                    5:                 new_limit = 0;
                    6, 7, 8, 9:        new_limit = $urandom_range(1, 16);
                    10, 11, 12, 13:    new_limit = $urandom_range(17, 256);
                    14, 15, 16, 17:    new_limit = $urandom_range(257, 1200);
                    default:           new_limit = $urandom_range(1201, 4095);
                endcase
                write_limit(new_limit);
                phase_left = $urandom_range(120, 250);
            end
            random_request();
            sent++;
            phase_left--;
            if ($urandom_range(0, 49) == 0)
                drain();
        end

        drain();
        repeat (100) @(negedge i_clk);

        $display("Covered %0d requests under %0d limit settings, including zero and saturation.",
                 request_count, limit_writes);
        $display("Checked %0d results; %0d finds hit a free block, %0d saw none free.",
                 result_count, hit_count, full_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
